// ===== hw/rtl/top4_bone_influence_table_unit_assert.svh =====
// ---------------------------------------------------------------------------
// top4 bone influence table: assertion macros
// shared helpers for the concurrent checks in the rtl modules
// ---------------------------------------------------------------------------
`ifndef TOP4_BONE_INFLUENCE_TABLE_UNIT_ASSERT_SVH
`define TOP4_BONE_INFLUENCE_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define TBIT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tbit check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define TBIT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tbit check failed");

`endif

// ===== hw/rtl/tbit_pkg.sv =====
// ---------------------------------------------------------------------------
// tbit_pkg
// types, constants and helpers shared by the bone influence table modules
// ---------------------------------------------------------------------------
package tbit_pkg;

  // fixed field widths
  localparam int VtxW  = 12;
  localparam int BoneW = 8;
  localparam int WtW   = 16;

  // weight 1.0 in unsigned q1.15
  localparam logic [WtW-1:0] WtOne = WtW'(1) << (WtW - 1);

  // result slots always shown at the output
  localparam int OutSlots = 4;

  // defaults for the top level parameters
  localparam int NumVerticesDef = 4096;
  localparam int SlotsDef       = 4;
  localparam int MaxBonesDef    = 256;

  // entries in the queue between front and back
  localparam int QueueDepth = 2;

  // reciprocal shift used for the vertex index reduction
  localparam int RecipShift = 24;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_UPDATE
  } back_state_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [VtxW-1:0]  vertex_index;
    logic [BoneW-1:0] bone_index;
    logic [WtW-1:0]   weight;
  } in_item_t;

  typedef struct packed {
    logic [BoneW-1:0] id_slot0;
    logic [BoneW-1:0] id_slot1;
    logic [BoneW-1:0] id_slot2;
    logic [BoneW-1:0] id_slot3;
    logic [WtW-1:0]   wt_slot0;
    logic [WtW-1:0]   wt_slot1;
    logic [WtW-1:0]   wt_slot2;
    logic [WtW-1:0]   wt_slot3;
  } out_item_t;

  // stored bone id width: enough for ids below max_bones, never above the field
  function automatic int id_width(input int max_bones);
    int w;
    if (max_bones >= (1 << BoneW)) begin
      w = BoneW;
    end else begin
      w = $clog2(max_bones);
    end
    return w;
  endfunction

  // address width of the vertex store
  function automatic int addr_width(input int num_vertices);
    int w;
    if (num_vertices > 1) begin
      w = $clog2(num_vertices);
    end else begin
      w = 1;
    end
    return w;
  endfunction

endpackage

// ===== hw/rtl/top4_bone_influence_table_unit.sv =====
// ---------------------------------------------------------------------------
// top4_bone_influence_table_unit
// per-vertex table of the strongest bone influences, kept sorted by weight
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   in_item_i  (cmd, vertex, bone, weight)
//  out      output     out_valid_o / out_stall_i out_item_o (four ids, four weights)
//  cfg      input      cfg_we_i                  cfg_wdata_i (no_bones)
//
//  - the back end takes one item at a time: a ram read, then update, write-back
//    and result load, with the registered ram read lying ahead of the write-back
//  - an item reaches the back through the capture register, the index reduction and the queue
//  - after reset a clearing pass writes zero to all NUM_VERTICES entries, one per
//    cycle; in_stall_o stays high during it, config writes still land
//  - a 2-entry queue lets the front keep accepting while the back waits on
//    out_stall_i; the result register holds its item while stalled
//
module top4_bone_influence_table_unit #(
  parameter int NUM_VERTICES = tbit_pkg::NumVerticesDef,
  parameter int SLOTS        = tbit_pkg::SlotsDef,
  parameter int MAX_BONES    = tbit_pkg::MaxBonesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tbit_pkg::in_item_t  in_item_i,
  // result output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tbit_pkg::out_item_t out_item_o,
  // no_bones register write
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);

  // queue word: insert flag, store address, bone id, saturated weight
  localparam int ItemW = 1 + tbit_pkg::addr_width(NUM_VERTICES) +
                         tbit_pkg::id_width(MAX_BONES) + tbit_pkg::WtW;

  logic             no_bones_q;
  logic             clearing;
  logic             q_push;
  logic             q_full;
  logic [ItemW-1:0] q_push_data;
  logic             q_pop;
  logic             q_valid;
  logic [ItemW-1:0] q_data;

  // mesh-without-bones flag; the user must change it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_bones_q <= 1'b0;
    end else if (cfg_we_i) begin
      no_bones_q <= cfg_wdata_i;
    end
  end

  // front: accept, saturate weight, classify, reduce vertex to address
  tbit_front #(
    .NUM_VERTICES (NUM_VERTICES),
    .MAX_BONES    (MAX_BONES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .block_i    (clearing),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  // decoupling queue between classification and the table update
  tbit_queue #(
    .Width (ItemW),
    .Depth (tbit_pkg::QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // back: store clear, entry read with write-back on insert, result register
  tbit_back #(
    .NUM_VERTICES (NUM_VERTICES),
    .SLOTS        (SLOTS),
    .MAX_BONES    (MAX_BONES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .no_bones_i  (no_bones_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hw/rtl/tbit_ram.sv =====
// ---------------------------------------------------------------------------
// tbit_ram
// single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module tbit_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [tbit_pkg::addr_width(Depth)-1:0]  waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [tbit_pkg::addr_width(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tbit_queue.sv =====
// ---------------------------------------------------------------------------
// tbit_queue
// short fifo between the front and the back of the influence table
// ---------------------------------------------------------------------------
`include "top4_bone_influence_table_unit_assert.svh"

module tbit_queue #(
  parameter int Width = 8,
  parameter int Depth = tbit_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // the front never writes a full queue, the back never reads an empty one
  `TBIT_ASSERT_IMP(a_no_overflow, cnt_q == CntW'(Depth), !push_i)
  `TBIT_ASSERT_IMP(a_no_underflow, cnt_q == '0, !pop_i)
  // fill count never goes past the depth
  `TBIT_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CntW'(Depth))

endmodule

// ===== hw/rtl/tbit_front.sv =====
// ---------------------------------------------------------------------------
// tbit_front
// accepts items, saturates the weight, classifies insert or read and
// reduces the vertex index to a store address
// ---------------------------------------------------------------------------
module tbit_front #(
  parameter int NUM_VERTICES = tbit_pkg::NumVerticesDef,
  parameter int MAX_BONES    = tbit_pkg::MaxBonesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tbit_pkg::in_item_t   in_item_i,
  input  logic                 block_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output logic [1 + tbit_pkg::addr_width(NUM_VERTICES) + tbit_pkg::id_width(MAX_BONES)
                + tbit_pkg::WtW - 1:0] q_data_o
);

  localparam int AW     = tbit_pkg::addr_width(NUM_VERTICES);
  localparam int IdW    = tbit_pkg::id_width(MAX_BONES);
  localparam int VtxW   = tbit_pkg::VtxW;
  localparam int WtW    = tbit_pkg::WtW;
  localparam int RecipW = tbit_pkg::RecipShift + 1;
  localparam int ProdW  = VtxW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'((64'd1 << tbit_pkg::RecipShift) / NUM_VERTICES);

  // stage a: captured item and reciprocal product
  logic             a_valid_q;
  logic             a_ins_q;
  logic [IdW-1:0]   a_bone_q;
  logic [WtW-1:0]   a_wt_q;
  logic [VtxW-1:0]  a_vtx_q;
  logic [ProdW-1:0] a_prod_q;

  logic             take;
  logic [ProdW-1:0] prod_d;
  logic [VtxW-1:0]  quot;
  logic [31:0]      quot_c;
  logic [VtxW-1:0]  rem_raw;
  logic [VtxW-1:0]  rem_fix;

  assign in_stall_o = block_i || (a_valid_q && q_full_i);
  assign take       = !in_stall_o;
  assign prod_d     = ProdW'(in_item_i.vertex_index) * ProdW'(Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (take) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_valid_i) begin
      a_ins_q  <= (in_item_i.cmd == tbit_pkg::CMD_INSERT) &&
                  (32'(in_item_i.bone_index) < 32'(MAX_BONES));
      a_bone_q <= IdW'(in_item_i.bone_index);
      a_wt_q   <= (in_item_i.weight > tbit_pkg::WtOne) ? tbit_pkg::WtOne
                                                       : in_item_i.weight;
      a_vtx_q  <= in_item_i.vertex_index;
      a_prod_q <= prod_d;
    end
  end

  // stage b: remainder from the estimated quotient, at most one correction
  always_comb begin
    quot    = VtxW'(a_prod_q >> tbit_pkg::RecipShift);
    quot_c  = 32'(quot) * 32'(NUM_VERTICES);
    rem_raw = a_vtx_q - VtxW'(quot_c);
    if (32'(rem_raw) >= 32'(NUM_VERTICES)) begin
      rem_fix = rem_raw - VtxW'(NUM_VERTICES);
    end else begin
      rem_fix = rem_raw;
    end
  end

  assign q_push_o = a_valid_q && !q_full_i;
  assign q_data_o = {a_ins_q, AW'(rem_fix), a_bone_q, a_wt_q};

endmodule

// ===== hw/rtl/tbit_back.sv =====
// ---------------------------------------------------------------------------
// tbit_back
// clears the store after reset, then reads one vertex entry per item,
// writes it back updated for inserts and drives the result register
// ---------------------------------------------------------------------------
`include "top4_bone_influence_table_unit_assert.svh"

module tbit_back #(
  parameter int NUM_VERTICES = tbit_pkg::NumVerticesDef,
  parameter int SLOTS        = tbit_pkg::SlotsDef,
  parameter int MAX_BONES    = tbit_pkg::MaxBonesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  logic [1 + tbit_pkg::addr_width(NUM_VERTICES) + tbit_pkg::id_width(MAX_BONES)
                + tbit_pkg::WtW - 1:0] q_data_i,
  output logic                 q_pop_o,
  output logic                 clearing_o,
  input  logic                 no_bones_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tbit_pkg::out_item_t  out_item_o
);

  localparam int AW     = tbit_pkg::addr_width(NUM_VERTICES);
  localparam int IdW    = tbit_pkg::id_width(MAX_BONES);
  localparam int WtW    = tbit_pkg::WtW;
  localparam int BoneW  = tbit_pkg::BoneW;
  localparam int SlotW  = WtW + IdW;
  localparam int EntryW = SLOTS * SlotW;
  localparam int OutN   = tbit_pkg::OutSlots;

  tbit_pkg::back_state_e state_q, state_d;

  logic [AW-1:0]  clr_q, clr_d;
  logic           q_ins;
  logic [AW-1:0]  q_addr;
  logic [IdW-1:0] q_bone;
  logic [WtW-1:0] q_wt;

  logic           cur_ins_q;
  logic [AW-1:0]  cur_addr_q;
  logic [IdW-1:0] cur_bone_q;
  logic [WtW-1:0] cur_wt_q;

  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [EntryW-1:0] ram_wdata;
  logic [EntryW-1:0] ram_rdata;

  logic [WtW-1:0] old_wt [SLOTS];
  logic [IdW-1:0] old_id [SLOTS];
  logic [WtW-1:0] sh_wt  [SLOTS];
  logic [IdW-1:0] sh_id  [SLOTS];
  logic [WtW-1:0] new_wt [SLOTS];
  logic [IdW-1:0] new_id [SLOTS];
  logic [SLOTS-1:0] lt;
  logic [SLOTS-1:0] lt_prev;
  logic [EntryW-1:0] new_entry;

  logic [BoneW-1:0] o_id [OutN];
  logic [WtW-1:0]   o_wt [OutN];

  logic                out_free;
  logic                out_load;
  logic                out_valid_q;
  tbit_pkg::out_item_t out_item_q, out_item_d;

  assign {q_ins, q_addr, q_bone, q_wt} = q_data_i;

  tbit_ram #(
    .Width (EntryW),
    .Depth (NUM_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_addr),
    .rdata_o (ram_rdata)
  );

  // sorted insert: stored weights never rise with the slot, so lt is a
  // run of zeros then ones and the first one marks the new slot
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      old_wt[s] = ram_rdata[s*SlotW +: WtW];
      old_id[s] = ram_rdata[s*SlotW + WtW +: IdW];
      lt[s]     = old_wt[s] < cur_wt_q;
    end
    sh_wt[0]   = '0;
    sh_id[0]   = '0;
    lt_prev[0] = 1'b0;
    for (int s = 1; s < SLOTS; s++) begin
      sh_wt[s]   = old_wt[s-1];
      sh_id[s]   = old_id[s-1];
      lt_prev[s] = lt[s-1];
    end
    for (int s = 0; s < SLOTS; s++) begin
      if (!cur_ins_q || !lt[s]) begin
        new_wt[s] = old_wt[s];
        new_id[s] = old_id[s];
      end else if (!lt_prev[s]) begin
        new_wt[s] = cur_wt_q;
        new_id[s] = cur_bone_q;
      end else begin
        new_wt[s] = sh_wt[s];
        new_id[s] = sh_id[s];
      end
      new_entry[s*SlotW +: SlotW] = {new_id[s], new_wt[s]};
    end
  end

  for (genvar j = 0; j < OutN; j++) begin : g_out
    if (j < SLOTS) begin : g_slot
      assign o_id[j] = BoneW'(new_id[j]);
      assign o_wt[j] = new_wt[j];
    end else begin : g_none
      assign o_id[j] = '0;
      assign o_wt[j] = '0;
    end
  end

  always_comb begin
    if (no_bones_i) begin
      out_item_d.id_slot0 = '0;
      out_item_d.id_slot1 = '0;
      out_item_d.id_slot2 = '0;
      out_item_d.id_slot3 = '0;
      out_item_d.wt_slot0 = tbit_pkg::WtOne;
      out_item_d.wt_slot1 = tbit_pkg::WtOne;
      out_item_d.wt_slot2 = tbit_pkg::WtOne;
      out_item_d.wt_slot3 = tbit_pkg::WtOne;
    end else begin
      out_item_d.id_slot0 = o_id[0];
      out_item_d.id_slot1 = o_id[1];
      out_item_d.id_slot2 = o_id[2];
      out_item_d.id_slot3 = o_id[3];
      out_item_d.wt_slot0 = o_wt[0];
      out_item_d.wt_slot1 = o_wt[1];
      out_item_d.wt_slot2 = o_wt[2];
      out_item_d.wt_slot3 = o_wt[3];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    q_pop_o   = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cur_addr_q;
    ram_wdata = new_entry;
    out_load  = 1'b0;
    case (state_q)
      tbit_pkg::BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == AW'(NUM_VERTICES - 1)) begin
          state_d = tbit_pkg::BK_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      tbit_pkg::BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ram_re  = 1'b1;
          state_d = tbit_pkg::BK_UPDATE;
        end
      end
      tbit_pkg::BK_UPDATE: begin
        if (out_free) begin
          out_load = 1'b1;
          ram_we   = cur_ins_q;
          state_d  = tbit_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = tbit_pkg::BK_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tbit_pkg::BK_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_ins_q  <= q_ins;
      cur_addr_q <= q_addr;
      cur_bone_q <= q_bone;
      cur_wt_q   <= q_wt;
    end
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign clearing_o  = (state_q == tbit_pkg::BK_CLEAR);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // work only starts once the clearing pass has swept the whole store
  `TBIT_ASSERT_IMP(a_clear_done, state_q == tbit_pkg::BK_IDLE, clr_q == AW'(NUM_VERTICES - 1))
  `TBIT_ASSERT_NXT(a_pop_to_update, q_pop_o, state_q == tbit_pkg::BK_UPDATE)

  // every entry handed out stays sorted strongest first
  for (genvar s = 1; s < SLOTS; s++) begin : g_sorted
    `TBIT_ASSERT_IMP(a_sorted, out_load, new_wt[s-1] >= new_wt[s])
  end

endmodule
